// ===== rtl/kia_pkg.sv =====
// ----------------------------------------------------------------------------
// kia_pkg
// Shared types and constants of the key to id allocation table.
// ----------------------------------------------------------------------------
package kia_pkg;

    localparam int DEF_ENTRIES   = 256;
    localparam int DEF_KEY_WIDTH = 32;

    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 8;
    localparam int COUNT_W  = 9;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ASSIGN  = 2'd0,
        OP_FIND    = 2'd1,
        OP_REVERSE = 2'd2,
        OP_CLEAR   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Control flags that walk the cell chain alongside id and key
    typedef struct packed {
        logic tok;
        logic hit;
    } link_ctl_t;

endpackage

// ===== rtl/kia_req_if.sv =====
// ----------------------------------------------------------------------------
// kia_req_if
// Request channel: opcode, key and index with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kia_req_if
    import kia_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key;
    logic [INDEX_W-1:0]  index;

    modport source (output valid, output opcode, output key, output index, input ready);
    modport sink   (input valid, input opcode, input key, input index, output ready);
endinterface

// ===== rtl/kia_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kia_rsp_if
// Response channel: status, id, presence flag, key and entry count.
// ----------------------------------------------------------------------------
interface kia_rsp_if
    import kia_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id_out;
    logic                was_present;
    logic [KEY_W-1:0]    key_out;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output id_out, output was_present,
                    output key_out, output entry_count, input ready);
    modport sink   (input valid, input status, input id_out, input was_present,
                    input key_out, input entry_count, output ready);
endinterface

// ===== rtl/kia_cell.sv =====
// ----------------------------------------------------------------------------
// kia_cell
// One table entry: holds a key, compares it against the broadcast search
// and hands the running hit, id and key on to the next cell every cycle.
// ----------------------------------------------------------------------------
module kia_cell
    import kia_pkg::*;
#(
    parameter int KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int CW        = 9,
    parameter int IW        = 8,
    parameter int IDX       = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [KEY_WIDTH-1:0] search_key,
    input  logic [CW-1:0]        search_idx,
    input  logic                 rev,
    input  logic [CW-1:0]        count,
    input  logic                 wr_en,
    input  logic [KEY_WIDTH-1:0] wr_key,
    input  link_ctl_t            prev_ctl,
    input  logic [IW-1:0]        prev_id,
    input  logic [KEY_WIDTH-1:0] prev_key,
    output link_ctl_t            next_ctl,
    output logic [IW-1:0]        next_id,
    output logic [KEY_WIDTH-1:0] next_key
);

    logic [KEY_WIDTH-1:0] key_reg;
    link_ctl_t            ctl_reg;
    logic [IW-1:0]        id_reg;
    logic [KEY_WIDTH-1:0] fwd_key_reg;
    logic                 live;
    logic                 here;

    assign live = CW'(IDX) < count;
    assign here = rev ? (CW'(IDX) == search_idx) : (live && (key_reg == search_key));

    always_ff @(posedge clk)
    begin
        if (wr_en && (count == CW'(IDX)))
        begin
            key_reg <= wr_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg.tok <= prev_ctl.tok;
            ctl_reg.hit <= prev_ctl.hit | here;
        end
    end

    // Keep the first hit further up the chain
    always_ff @(posedge clk)
    begin
        id_reg      <= prev_ctl.hit ? prev_id  : IW'(IDX);
        fwd_key_reg <= prev_ctl.hit ? prev_key : key_reg;
    end

    assign next_ctl = ctl_reg;
    assign next_id  = id_reg;
    assign next_key = fwd_key_reg;

endmodule

// ===== rtl/kia_ctrl.sv =====
// ----------------------------------------------------------------------------
// kia_ctrl
// Sequencer: takes a request, launches a search token down the cell chain,
// captures the chain tail, works out the response and updates the count.
// ----------------------------------------------------------------------------
module kia_ctrl
    import kia_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int CW        = $clog2(ENTRIES + 1),
    parameter int IW        = $clog2(ENTRIES)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    kia_req_if.sink              req,
    kia_rsp_if.source            rsp,
    output logic [KEY_WIDTH-1:0] search_key,
    output logic [CW-1:0]        search_idx,
    output logic                 rev,
    output logic [CW-1:0]        count,
    output logic                 wr_en,
    output logic [KEY_WIDTH-1:0] wr_key,
    output link_ctl_t            head_ctl,
    input  link_ctl_t            tail_ctl,
    input  logic [IW-1:0]        tail_id,
    input  logic [KEY_WIDTH-1:0] tail_key
);

    localparam int RW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_EMIT   = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    opcode_t              op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic                 start_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic                 hit_reg;
    logic [IW-1:0]        hid_reg;
    logic [KEY_WIDTH-1:0] hkey_reg;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic                 out_present_reg;
    logic [KEY_W-1:0]     out_key_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic                 accept;
    logic                 emit_go;
    logic                 full;
    logic                 in_range;
    status_t              status_n;
    logic [IW-1:0]        id_n;
    logic                 present_n;
    logic [KEY_WIDTH-1:0] kout_n;
    logic                 insert;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign emit_go   = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);
    assign full      = (count_reg == CW'(ENTRIES));
    assign in_range  = RW'(index_reg) < RW'(count_reg);

    always_comb
    begin
        status_n   = ST_OK;
        id_n       = '0;
        present_n  = 1'b0;
        kout_n     = '0;
        insert     = 1'b0;
        count_next = count_reg;
        case (op_reg)
            OP_ASSIGN:
            begin
                if (hit_reg)
                begin
                    id_n      = hid_reg;
                    present_n = 1'b1;
                end
                else if (full)
                begin
                    status_n = ST_FULL;
                end
                else
                begin
                    id_n       = IW'(count_reg);
                    insert     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_FIND:
            begin
                if (hit_reg)
                begin
                    id_n      = hid_reg;
                    present_n = 1'b1;
                end
                else
                begin
                    status_n = ST_NOT_FOUND;
                end
            end
            OP_REVERSE:
            begin
                if (in_range)
                begin
                    kout_n = hkey_reg;
                end
                else
                begin
                    status_n = ST_RANGE;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tail_ctl.tok)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= accept;
            out_valid_reg <= out_valid_next;
            if (emit_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode_t'(req.opcode);
            key_reg   <= KEY_WIDTH'(req.key);
            index_reg <= req.index;
        end
        // Hold the tail of the chain as the token drops out
        if ((state_reg == S_SEARCH) && tail_ctl.tok)
        begin
            hit_reg  <= tail_ctl.hit;
            hid_reg  <= tail_id;
            hkey_reg <= tail_key;
        end
        if (emit_go)
        begin
            out_status_reg  <= status_n;
            out_id_reg      <= ID_W'(id_n);
            out_present_reg <= present_n;
            out_key_reg     <= KEY_W'(kout_n);
            out_count_reg   <= COUNT_W'(count_next);
        end
    end

    assign search_key = key_reg;
    assign search_idx = CW'(index_reg);
    assign rev        = (op_reg == OP_REVERSE);
    assign count      = count_reg;
    assign wr_en      = emit_go && insert;
    assign wr_key     = key_reg;
    assign head_ctl   = '{tok: start_reg, hit: 1'b0};

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.id_out      = out_id_reg;
    assign rsp.was_present = out_present_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("entry count beyond table size");

    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tail_ctl.tok |-> (state_reg == S_SEARCH))
        else $error("search token at chain tail outside search");

    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (start_reg && (state_reg == S_SEARCH)))
        else $error("accepted beat did not launch a search");

    a_count_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(emit_go))
        else $error("entry count moved without a response");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!full && !hit_reg && (op_reg == OP_ASSIGN)))
        else $error("insert into full table or over an existing key");

endmodule

// ===== rtl/key_to_id_allocation_table_unit.sv =====
// Flow: an accepted request beat sets start_reg, the search token walks the
// cell chain one cell per cycle, the tail is captured and the response is registered;
// the next request waits for the token to finish and the response to be emitted.
// A response held in the output register does not block the next request.
// Reset: entry count goes to zero; the key store is not cleared.
// ----------------------------------------------------------------------------
// key_to_id_allocation_table_unit
// Maps keys to dense ids in order of first appearance, with find, reverse
// lookup and clear, over a chain of entry cells.
// ----------------------------------------------------------------------------
module key_to_id_allocation_table_unit
    import kia_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    kia_req_if.sink   req,
    kia_rsp_if.source rsp
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = $clog2(ENTRIES);

    logic [KEY_WIDTH-1:0] search_key;
    logic [CW-1:0]        search_idx;
    logic                 rev;
    logic [CW-1:0]        count;
    logic                 wr_en;
    logic [KEY_WIDTH-1:0] wr_key;

    link_ctl_t            link_ctl [ENTRIES+1];
    logic [IW-1:0]        link_id  [ENTRIES+1];
    logic [KEY_WIDTH-1:0] link_key [ENTRIES+1];

    assign link_id[0]  = '0;
    assign link_key[0] = '0;

    kia_ctrl #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH),
        .CW        (CW),
        .IW        (IW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .search_key (search_key),
        .search_idx (search_idx),
        .rev        (rev),
        .count      (count),
        .wr_en      (wr_en),
        .wr_key     (wr_key),
        .head_ctl   (link_ctl[0]),
        .tail_ctl   (link_ctl[ENTRIES]),
        .tail_id    (link_id[ENTRIES]),
        .tail_key   (link_key[ENTRIES])
    );

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        kia_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CW        (CW),
            .IW        (IW),
            .IDX       (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .search_key (search_key),
            .search_idx (search_idx),
            .rev        (rev),
            .count      (count),
            .wr_en      (wr_en),
            .wr_key     (wr_key),
            .prev_ctl   (link_ctl[g]),
            .prev_id    (link_id[g]),
            .prev_key   (link_key[g]),
            .next_ctl   (link_ctl[g+1]),
            .next_id    (link_id[g+1]),
            .next_key   (link_key[g+1])
        );
    end

endmodule

// ===== tb/key_to_id_allocation_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_to_id_allocation_table_unit_tb
// Self-checking bench for the key to id table. A directed opening covers
// empty-table lookups, repeated keys, misses, reverse lookups at and past the
// entry count and clears. Random traffic follows, in segments over small key
// pools and in passes that fill the table and then hit the full case. Each
// accepted request is predicted on the spot, and every response beat is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module key_to_id_allocation_table_unit_tb;
    import kia_pkg::*;

    localparam int TABLE_DEPTH   = DEF_ENTRIES;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int TAIL_ITEMS    = 150;
    localparam int SETTLE_CYCLES = DEF_ENTRIES + 16;

    typedef struct {
        opcode_t            op;
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
        bit                 drain;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    id_out;
        logic               was_present;
        logic [KEY_W-1:0]   key_out;
        logic [COUNT_W-1:0] entry_count;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    kia_req_if req ();
    kia_rsp_if rsp ();

    key_to_id_allocation_table_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    request_t         queued_requests[$];
    answer_t          due_answers[$];
    logic [KEY_W-1:0] id_keys [TABLE_DEPTH];
    int unsigned      id_count   = 0;
    bit               plan_keys [logic [KEY_W-1:0]];
    int unsigned      plan_count = 0;
    int unsigned      n_issued   = 0;
    int unsigned      n_accepted = 0;
    int unsigned      n_total    = 0;
    int unsigned      n_errors   = 0;
    int unsigned      send_gap   = 0;
    int unsigned      stall_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the response it owes
    function automatic answer_t table_apply(opcode_t op, logic [KEY_W-1:0] k,
                                            logic [INDEX_W-1:0] idx);
        answer_t a;
        int      slot;
        a = '0;
        a.status = ST_OK;
        slot = -1;
        if (op == OP_ASSIGN || op == OP_FIND)
        begin
            for (int i = 0; i < id_count; i++)
                if (slot < 0 && id_keys[i] == k)
                    slot = i;
        end
        case (op)
            OP_ASSIGN:
            begin
                if (slot >= 0)
                begin
                    a.id_out      = ID_W'(slot);
                    a.was_present = 1'b1;
                end
                else if (id_count >= TABLE_DEPTH)
                    a.status = ST_FULL;
                else
                begin
                    id_keys[id_count] = k;
                    a.id_out          = ID_W'(id_count);
                    id_count++;
                end
            end
            OP_FIND:
            begin
                if (slot >= 0)
                begin
                    a.id_out      = ID_W'(slot);
                    a.was_present = 1'b1;
                end
                else
                    a.status = ST_NOT_FOUND;
            end
            OP_REVERSE:
            begin
                if (idx < id_count)
                    a.key_out = id_keys[idx];
                else
                    a.status = ST_RANGE;
            end
            default:
                id_count = 0;
        endcase
        a.entry_count = COUNT_W'(id_count);
        return a;
    endfunction

    // Queue a request and track roughly how full the table will be
    task automatic plan_request(opcode_t op, logic [KEY_W-1:0] k, logic [INDEX_W-1:0] idx,
                                bit drain = 1'b0);
        request_t r;
        r = '{op, k, idx, drain};
        queued_requests.insert(queued_requests.size(), r);
        if (op == OP_CLEAR)
        begin
            plan_keys.delete();
            plan_count = 0;
        end
        else if (op == OP_ASSIGN && !plan_keys.exists(k) && plan_count < TABLE_DEPTH)
        begin
            plan_keys[k] = 1'b1;
            plan_count++;
        end
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
            3:       return ~(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic check_field(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // Request driver: hold a beat until taken, otherwise idle, wait or send
    always @(negedge clk)
    begin
        request_t item;
        bit       send;
        send = 1'b0;
        if (!rst_n)
        begin
            req.valid  <= 1'b0;
            req.opcode <= OP_ASSIGN;
            req.key    <= '0;
            req.index  <= '0;
        end
        else if (!(req.valid && n_accepted != n_issued))
        begin
            if (send_gap > 0)
                send_gap--;
            else if (queued_requests.size() != 0 &&
                     !(queued_requests[0].drain && due_answers.size() != 0))
            begin
                if (n_accepted + TAIL_ITEMS < n_total && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 18) - 1;
                else
                begin
                    item = queued_requests.pop_front();
                    send = 1'b1;
                    n_issued++;
                end
            end
            if (send)
            begin
                req.valid  <= 1'b1;
                req.opcode <= item.op;
                req.key    <= item.key;
                req.index  <= item.index;
            end
            else
            begin
                req.valid  <= 1'b0;
                req.opcode <= OPCODE_W'($urandom);
                req.key    <= KEY_W'($urandom);
                req.index  <= INDEX_W'($urandom);
            end
        end
    end

    // Response ready: random stall bursts, none in the closing stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp.ready <= 1'b0;
        end
        else if (n_accepted + TAIL_ITEMS < n_total && $urandom_range(0, 39) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // Monitor: check response beats, then predict newly accepted requests
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (rsp.valid === 1'b1 && rsp.ready)
            begin
                if (due_answers.size() == 0)
                begin
                    n_errors++;
                    $display("%0t ns: stray response, expected none, actual %0d/%0d/0x%0h/%0d",
                             $time, rsp.status, rsp.id_out, rsp.key_out, rsp.entry_count);
                end
                else
                begin
                    want = due_answers.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("id_out", want.id_out, rsp.id_out);
                    check_field("was_present", want.was_present, rsp.was_present);
                    check_field("key_out", want.key_out, rsp.key_out);
                    check_field("entry_count", want.entry_count, rsp.entry_count);
                end
            end
            if (req.valid && req.ready === 1'b1)
            begin
                due_answers.insert(due_answers.size(),
                                   table_apply(opcode_t'(req.opcode), req.key, req.index));
                n_accepted++;
            end
        end
    end

    initial
    begin
        logic [KEY_W-1:0]   pool[$];
        logic [KEY_W-1:0]   k;
        logic [INDEX_W-1:0] idx;
        opcode_t            op;
        int unsigned        seg_len;
        int unsigned        roll;
        int unsigned        n_fills;
        int unsigned        n_segs;
        int unsigned        start_len;
        bit                 fill_mode;
        bit                 drain_next;

        rst_n      = 1'b0;

        // Empty table first, then hits, misses, range edges and clears
        plan_request(OP_FIND, '0, '0);
        plan_request(OP_REVERSE, '0, '0);
        plan_request(OP_REVERSE, '1, '1);
        plan_request(OP_ASSIGN, '0, '0);
        plan_request(OP_ASSIGN, '1, '1);
        plan_request(OP_ASSIGN, '0, '1);
        plan_request(OP_FIND, '1, 8'h5a);
        plan_request(OP_FIND, 32'ha5a5a5a5, '0);
        plan_request(OP_REVERSE, '1, 8'd0);
        plan_request(OP_REVERSE, '0, 8'd1);
        plan_request(OP_REVERSE, '0, 8'd2);
        plan_request(OP_CLEAR, 32'h12345678, 8'hff);
        plan_request(OP_CLEAR, '0, '0);
        // Stale contents after a clear must not match
        plan_request(OP_FIND, '1, '0);
        plan_request(OP_REVERSE, '0, 8'd1);
        plan_request(OP_ASSIGN, 32'h5a5a5a5a, '0);
        plan_request(OP_ASSIGN, '1, '0);
        plan_request(OP_ASSIGN, 32'h80000000, 8'h80);
        plan_request(OP_ASSIGN, 32'h00000001, '0);
        plan_request(OP_REVERSE, '0, 8'd3);
        plan_request(OP_FIND, 32'h80000000, '0);
        plan_request(OP_REVERSE, '0, 8'd4);

        n_fills   = 0;
        n_segs    = 0;
        start_len = queued_requests.size();
        while (queued_requests.size() - start_len < RANDOM_ITEMS)
        begin
            fill_mode = (n_segs == 0) || (n_fills < 2 && $urandom_range(0, 5) == 0);
            n_fills  += fill_mode;
            pool.delete();
            if (!fill_mode)
                repeat ($urandom_range(1, 48)) pool.insert(pool.size(), fresh_key());
            // A fill pass only starts counting down once the table is full
            seg_len    = fill_mode ? 40 : $urandom_range(10, 90);
            drain_next = (n_segs == 1) || ($urandom_range(0, 2) == 0);
            while (seg_len > 0)
            begin
                roll = $urandom_range(0, 99);
                if (pool.size() > 0 && $urandom_range(0, 3) != 0)
                    k = pool[$urandom_range(0, pool.size() - 1)];
                else
                    k = fresh_key();
                if ($urandom_range(0, 2) != 0)
                    idx = INDEX_W'($urandom_range(0, plan_count));
                else
                    idx = INDEX_W'($urandom);
                if (roll < 5)
                begin
                    op = opcode_t'($urandom_range(0, 3));
                    if (fill_mode && op == OP_CLEAR)
                        op = OP_FIND;
                    k   = KEY_W'($urandom);
                    idx = INDEX_W'($urandom);
                end
                else if (roll < (fill_mode ? 80 : 20))
                begin
                    op = OP_ASSIGN;
                    k  = fresh_key();
                    pool.insert(pool.size(), k);
                end
                else if (roll < (fill_mode ? 88 : 45))
                    op = OP_ASSIGN;
                else if (roll < (fill_mode ? 94 : 80))
                    op = OP_FIND;
                else if (roll < 98 || fill_mode)
                    op = OP_REVERSE;
                else
                    op = OP_CLEAR;
                plan_request(op, k, idx, drain_next);
                drain_next = 1'b0;
                if (!fill_mode || plan_count >= TABLE_DEPTH)
                    seg_len--;
            end
            if (fill_mode || $urandom_range(0, 1) == 0)
                plan_request(OP_CLEAR, KEY_W'($urandom), INDEX_W'($urandom));
            n_segs++;
        end
        n_total = queued_requests.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(queued_requests.size() == 0 && n_accepted == n_issued &&
                 due_answers.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
